// ----- rtl/swrr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared types, codes and helpers for the smooth weighted round-robin table.
// ----------------------------------------------------------------------------
package swrr_pkg;

  // Default and largest supported number of table entries.
  localparam int ENTRIES_DEF = 16;
  localparam int IDX_W       = 8;   // holds any slot index up to 256 entries
  localparam int SLOT_W      = 4;
  localparam int WEIGHT_W    = 32;
  localparam int RANK_W      = 8;
  localparam int RV_W        = 48;
  localparam int SCORE_W     = RV_W + 1;
  localparam int TOTAL_W     = WEIGHT_W + IDX_W;
  localparam int UPD_W       = RV_W + 2;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_SELECT = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTCONN = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // Running value limits, sign-extended to the update width.
  localparam logic signed [UPD_W-1:0] RV_MAX_EXT = UPD_W'(signed'(49'h0_7FFF_FFFF_FFFF));
  localparam logic signed [UPD_W-1:0] RV_MIN_EXT = -RV_MAX_EXT - UPD_W'(1);

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [RANK_W-1:0]   tie_rank;
  } swrr_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] chosen_slot;
  } swrr_out_t;

  // Table edit broadcast to every cell.
  typedef struct packed {
    logic                wr_en;
    logic [1:0]          req_type;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [RANK_W-1:0]   tie_rank;
  } swrr_cmd_t;

  // Best-so-far record handed from cell to cell during a scan.
  typedef struct packed {
    logic               live;
    logic               any_valid;
    logic               found;
    logic [SCORE_W-1:0] best_score;
    logic [RANK_W-1:0]  best_rank;
    logic [IDX_W-1:0]   best_idx;
    logic [TOTAL_W-1:0] total;
  } swrr_scan_t;

  // Winner broadcast that applies the running value update.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   win_idx;
    logic [TOTAL_W-1:0] total;
  } swrr_commit_t;

  // Clamp an exact update result to the signed 48-bit range.
  function automatic logic [RV_W-1:0] sat_rv(input logic signed [UPD_W-1:0] v);
    logic [RV_W-1:0] res;
    if (v > RV_MAX_EXT) begin
      res = RV_MAX_EXT[RV_W-1:0];
    end else if (v < RV_MIN_EXT) begin
      res = RV_MIN_EXT[RV_W-1:0];
    end else begin
      res = v[RV_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/swrr_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrr_cell
// One table entry. Applies edits, folds itself into the passing scan record
// and applies the running value update when a winner is committed.
// ----------------------------------------------------------------------------
module swrr_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swrr_pkg::swrr_cmd_t    cmd,
  input  swrr_pkg::swrr_scan_t   scan_i,
  output swrr_pkg::swrr_scan_t   scan_o,
  input  swrr_pkg::swrr_commit_t commit
);
  import swrr_pkg::*;

  logic                valid_r;
  logic                valid_nxt;
  logic [WEIGHT_W-1:0] weight_r;
  logic [WEIGHT_W-1:0] weight_nxt;
  logic [RANK_W-1:0]   rank_r;
  logic [RANK_W-1:0]   rank_nxt;
  logic [RV_W-1:0]     rv_r;
  logic [RV_W-1:0]     rv_nxt;
  logic                live_r;
  swrr_scan_t          scan_r;
  swrr_scan_t          scan_nxt;

  logic                hit;
  logic                active;
  logic signed [SCORE_W-1:0] score;
  logic                take;
  logic signed [UPD_W-1:0]   upd;

  assign hit    = cmd.wr_en && ({{(IDX_W-SLOT_W){1'b0}}, cmd.slot} == IDX_W'(CELL_IDX));
  assign active = valid_r && (weight_r != '0);
  assign score  = $signed({rv_r[RV_W-1], rv_r}) + $signed({{(SCORE_W-WEIGHT_W){1'b0}}, weight_r});

  // Running value after a select: add the weight, and take the total off the winner.
  always_comb begin
    upd = $signed({{(UPD_W-RV_W){rv_r[RV_W-1]}}, rv_r})
        + $signed({{(UPD_W-WEIGHT_W){1'b0}}, weight_r});
    if (commit.win_idx == IDX_W'(CELL_IDX)) begin
      upd = upd - $signed({{(UPD_W-TOTAL_W){1'b0}}, commit.total});
    end
  end

  // Entry edits and the select update.
  always_comb begin
    valid_nxt  = valid_r;
    weight_nxt = weight_r;
    rank_nxt   = rank_r;
    rv_nxt     = rv_r;
    if (hit) begin
      case (cmd.req_type)
        REQ_INSERT: begin
          valid_nxt  = 1'b1;
          weight_nxt = cmd.weight;
          rank_nxt   = cmd.tie_rank;
          rv_nxt     = '0;
        end
        REQ_UPDATE: begin
          weight_nxt = cmd.weight;
          if (!valid_r) begin
            valid_nxt = 1'b1;
            rank_nxt  = cmd.tie_rank;
            rv_nxt    = '0;
          end
        end
        REQ_REMOVE: begin
          valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (commit.en && active) begin
      rv_nxt = sat_rv(upd);
    end
  end

  // Fold this entry into the best-so-far record from the left neighbor.
  always_comb begin
    scan_nxt           = scan_i;
    scan_nxt.any_valid = scan_i.any_valid | valid_r;
    take = !scan_i.found
        || (score > $signed(scan_i.best_score))
        || ((score == $signed(scan_i.best_score)) && (rank_r < scan_i.best_rank));
    if (active) begin
      scan_nxt.total = scan_i.total + TOTAL_W'(weight_r);
      if (take) begin
        scan_nxt.found      = 1'b1;
        scan_nxt.best_score = score;
        scan_nxt.best_rank  = rank_r;
        scan_nxt.best_idx   = IDX_W'(CELL_IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      live_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      live_r  <= scan_i.live;
    end
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    rank_r   <= rank_nxt;
    rv_r     <= rv_nxt;
    if (scan_i.live) begin
      scan_r <= scan_nxt;
    end
  end

  always_comb begin
    scan_o      = scan_r;
    scan_o.live = live_r;
  end

endmodule

// ----- rtl/smooth_weighted_round_robin_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_weighted_round_robin_table
// Route table with smooth weighted round-robin selection over a row of cells.
// ----------------------------------------------------------------------------
// Insert, update and remove: result in the cycle after the transfer; busy stays
// low, so a new transfer can follow in the next cycle.
// Select: the best-so-far record walks the row of cells one cell per cycle, and
// the result is registered from the record that leaves the last cell; busy stays
// high while the record walks the row, so the next transfer can meet the result.
// Reset clears every valid mark at once; the one-cycle result strobe cannot stall.
module smooth_weighted_round_robin_table #(
  parameter int ENTRIES = swrr_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swrr_pkg::swrr_in_t  in_data,
  output logic                out_valid,
  output swrr_pkg::swrr_out_t out_data
);
  import swrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t       state_r;
  state_t       state_nxt;
  logic         head_live_r;
  logic         head_live_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  swrr_out_t    out_data_r;
  swrr_out_t    out_data_nxt;

  logic         accept;
  swrr_cmd_t    cmd;
  swrr_commit_t commit;
  swrr_scan_t   scan [ENTRIES+1];
  swrr_scan_t   tail;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Edits reach the cells on the transfer edge.
  always_comb begin
    cmd.wr_en    = accept && (in_data.req_type != REQ_SELECT);
    cmd.req_type = in_data.req_type;
    cmd.slot     = in_data.slot;
    cmd.weight   = in_data.weight;
    cmd.tie_rank = in_data.tie_rank;
  end

  // The scan record enters the row empty.
  always_comb begin
    scan[0]      = '0;
    scan[0].live = head_live_r;
  end

  assign tail = scan[ENTRIES];

  // Winner broadcast when the record leaves the last cell.
  always_comb begin
    commit.en      = (state_r == S_SCAN) && tail.live && tail.found;
    commit.win_idx = tail.best_idx;
    commit.total   = tail.total;
  end

  // Row of cells.
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    swrr_cell #(
      .CELL_IDX(gi)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .scan_i (scan[gi]),
      .scan_o (scan[gi+1]),
      .commit (commit)
    );
  end

  // Request sequencing and result formation.
  always_comb begin
    state_nxt     = state_r;
    head_live_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_SELECT) begin
            head_live_nxt = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.status      = ST_OK;
            out_data_nxt.chosen_slot = '0;
          end
        end
      end
      S_SCAN: begin
        if (tail.live) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (tail.found) begin
            out_data_nxt.status      = ST_OK;
            out_data_nxt.chosen_slot = tail.best_idx[SLOT_W-1:0];
          end else begin
            out_data_nxt.status      = tail.any_valid ? ST_REFUSED : ST_NOTCONN;
            out_data_nxt.chosen_slot = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_live_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_live_r <= head_live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
